// ----- design/swma_pkg.sv -----
// Package: shared types and constants for the sliding window median alert block.
`timescale 1ns / 1ps
package swma_pkg;
   localparam int SampleWidth = 8;
   localparam int LengthWidth = 11;
   localparam int MedianWidth = 9;
   localparam int TotalWidth  = 16;

   typedef struct packed {
      logic                   window_full;
      logic [MedianWidth-1:0] doubled_median;
      logic                   alert;
      logic [TotalWidth-1:0]  alert_total;
   } rsp_type;

   // Control word broadcast to every cell of the bin cell row.
   typedef struct packed {
      logic clear;
      logic inc;
      logic dec;
   } cell_ctl_type;
endpackage

// ----- design/swma_if.sv -----
// Interfaces: valid/ready channels for samples and results.
`timescale 1ns / 1ps
interface swma_req_if;
   logic                             valid;
   logic                             ready;
   logic [swma_pkg::SampleWidth-1:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface swma_rsp_if;
   logic                   valid;
   logic                   ready;
   swma_pkg::rsp_type      payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/swma_bin_cell.sv -----
// Bin cell: one histogram count, passes a running prefix sum to its neighbour.
`timescale 1ns / 1ps
module swma_bin_cell #(
   parameter int CountWidth = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swma_pkg::cell_ctl_type  ctl,
   input  logic                    inc_sel,
   input  logic                    dec_sel,
   input  logic                    shift,
   input  logic [CountWidth-1:0]   prefix_prev,
   output logic [CountWidth-1:0]   prefix_out,
   output logic                    occupied
);
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] prefix_ff, prefix_in;
   logic [CountWidth-1:0] dec_val;

   always_comb begin
      dec_val = count_ff;
      if (ctl.dec && dec_sel && count_ff != '0) begin
         dec_val = count_ff - 1'b1;
      end
      count_in = dec_val;
      if (ctl.inc && inc_sel) begin
         count_in = dec_val + 1'b1;
      end
      if (ctl.clear) begin
         count_in = '0;
      end
      // Hold a snapshot of the prefix up to this bin; advance while shift is high.
      prefix_in = prefix_ff;
      if (shift) begin
         prefix_in = prefix_prev + count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      prefix_ff <= prefix_in;
   end

   assign prefix_out = prefix_ff;
   assign occupied   = count_ff != '0;
endmodule

// ----- design/sliding_window_median_alert.sv -----
// Top level: sliding window median alert built on a row of histogram bin cells.
`timescale 1ns / 1ps
// Usage:
//   req channel carries one 8-bit sample_value per beat. rsp channel returns
//   one beat per sample: window_full, doubled_median, alert and alert_total.
//   csr_write_enable/csr_write_data set window_length; a write restarts the
//   window (histogram cleared, fill level and ring position to zero) while
//   the alert total is kept. Write it only while the block is idle.
// Timing:
//   Each sample is taken one at a time. While the window fills, an accepted
//   sample passes through the histogram update and then the output stage.
//   Once full, the row of bin cells first settles the prefix counts, then a
//   bin scanner walks the bins one per cycle (at most NUM_BINS), then the
//   histogram is updated and the result leaves; the next sample is taken
//   once the block is back in idle.
//   The ring is read in the acceptance cycle; its read port sets no limit.
// Reset:
//   Synchronous, active high. All bins clear at once, window_length returns
//   to 1, the alert total to zero. The ring needs no clearing.
// Stall:
//   A result waits in the output register until rsp ready is high. The next
//   sample is still accepted and worked on; its result holds in the output
//   stage until the waiting beat has gone.
module sliding_window_median_alert #(
   parameter int NUM_BINS   = 256,
   parameter int WINDOW_MAX = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [swma_pkg::LengthWidth-1:0]    csr_write_data,
   swma_req_if.sink                            req,
   swma_rsp_if.source                          rsp
);
   localparam int BinBits  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int PosBits  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CntW     = $clog2(WINDOW_MAX + 1);
   localparam int WalkW    = $clog2(2 * NUM_BINS + 2);
   localparam int CntW1    = CntW + 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SETTLE = 6'b000010,
      S_LOWER  = 6'b000100,
      S_UPPER  = 6'b001000,
      S_UPDATE = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [swma_pkg::LengthWidth-1:0] length_ff;
   logic [CntW-1:0]       len_eff;
   logic [PosBits-1:0]    pos_ff, pos_in;
   logic [CntW-1:0]       fill_ff, fill_in;
   logic [swma_pkg::TotalWidth-1:0] total_ff, total_in;
   logic [BinBits-1:0]    sample_ff, old_ff;
   logic [BinBits-1:0]    sample_bin;
   logic                  full_ff, full_in;
   logic [WalkW-1:0]      walk_ff, walk_in;
   logic [BinBits-1:0]    bin_ff, bin_in;
   logic [BinBits:0]      lower_ff, lower_in;
   logic [swma_pkg::MedianWidth-1:0] median_ff, median_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   swma_pkg::rsp_type     rsp_ff, rsp_in;

   logic [swma_pkg::SampleWidth-1:0] ring_mem [WINDOW_MAX];
   logic [swma_pkg::SampleWidth-1:0] ring_q;

   logic [CntW-1:0]       prefix [NUM_BINS+1];
   logic [CntW-1:0]       cum [NUM_BINS];
   logic [NUM_BINS-1:0]   occ;
   swma_pkg::cell_ctl_type ctl;
   logic                  accept;
   logic [CntW-1:0]       middle;
   logic [CntW1-1:0]      middle_p1;
   logic                  odd;

   // Clamp the window length into 1..WINDOW_MAX.
   always_comb begin
      if (length_ff == '0) begin
         len_eff = CntW'(1);
      end else if (32'(length_ff) > WINDOW_MAX) begin
         len_eff = CntW'(WINDOW_MAX);
      end else begin
         len_eff = CntW'(length_ff);
      end
   end

   assign odd       = len_eff[0];
   assign middle    = odd ? (len_eff >> 1) : ((len_eff >> 1) - 1'b1);
   assign middle_p1 = CntW1'(middle) + 1'b1;

   // Values beyond the bins land in the top bin.
   assign sample_bin = (32'(req.sample_value) >= NUM_BINS) ? BinBits'(NUM_BINS - 1)
                                                           : BinBits'(req.sample_value);

   assign req.ready = state_ff == S_IDLE;
   assign accept    = req.valid && req.ready;

   // Ring memory: read old sample and write new one on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_q <= ring_mem[pos_ff];
         ring_mem[pos_ff] <= swma_pkg::SampleWidth'(sample_bin);
      end
   end

   // Row of bin cells; the prefix ripples one cell per cycle.
   assign prefix[0] = '0;
   genvar g;
   generate
      for (g = 0; g < NUM_BINS; g++) begin : g_bin
         swma_bin_cell #(.CountWidth(CntW)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .inc_sel     (sample_ff == BinBits'(g)),
            .dec_sel     (old_ff == BinBits'(g)),
            .shift       (state_ff == S_SETTLE),
            .prefix_prev (prefix[g]),
            .prefix_out  (prefix[g+1]),
            .occupied    (occ[g])
         );
         // Count of all values up to and including this bin.
         assign cum[g] = prefix[g+1];
      end
   endgenerate

   always_comb begin
      ctl.clear = csr_write_enable;
      ctl.inc   = state_ff == S_UPDATE;
      ctl.dec   = state_ff == S_UPDATE && full_ff;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      full_in      = full_ff;
      walk_in      = walk_ff;
      bin_in       = bin_ff;
      lower_in     = lower_ff;
      median_in    = median_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               full_in  = fill_ff >= len_eff;
               walk_in  = '0;
               bin_in   = '0;
               median_in = '0;
               state_in = (fill_ff >= len_eff) ? S_SETTLE : S_UPDATE;
               pos_in   = (32'(pos_ff) + 1 >= 32'(len_eff)) ? '0 : pos_ff + 1'b1;
            end
         end
         S_SETTLE: begin
            walk_in = walk_ff + 1'b1;
            if (32'(walk_ff) == NUM_BINS) begin
               state_in = S_LOWER;
            end
         end
         S_LOWER: begin
            // Advance one bin a cycle until the prefix passes the middle.
            if (cum[bin_ff] > middle) begin
               if (odd || CntW1'(cum[bin_ff]) > middle_p1 ||
                   32'(bin_ff) == NUM_BINS - 1) begin
                  median_in = swma_pkg::MedianWidth'({bin_ff, 1'b0});
                  state_in  = S_UPDATE;
               end else begin
                  lower_in = {1'b0, bin_ff};
                  bin_in   = bin_ff + 1'b1;
                  state_in = S_UPPER;
               end
            end else if (32'(bin_ff) == NUM_BINS - 1) begin
               median_in = '0;
               state_in  = S_UPDATE;
            end else begin
               bin_in = bin_ff + 1'b1;
            end
         end
         S_UPPER: begin
            if (occ[bin_ff]) begin
               median_in = swma_pkg::MedianWidth'(lower_ff + bin_ff);
               state_in  = S_UPDATE;
            end else if (32'(bin_ff) == NUM_BINS - 1) begin
               median_in = swma_pkg::MedianWidth'({lower_ff, 1'b0});
               state_in  = S_UPDATE;
            end else begin
               bin_in = bin_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            if (!full_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold here while the previous beat still waits.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in.window_full    = full_ff;
               rsp_in.doubled_median = full_ff ? median_ff : '0;
               rsp_in.alert          = full_ff && (9'(sample_ff) >= median_ff);
               if (full_ff && (9'(sample_ff) >= median_ff) && total_ff != '1) begin
                  total_in = total_ff + 1'b1;
                  rsp_in.alert_total = total_ff + 1'b1;
               end else begin
                  rsp_in.alert_total = total_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_write_enable) begin
         pos_in  = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= swma_pkg::LengthWidth'(1);
         pos_ff       <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      full_ff   <= full_in;
      walk_ff   <= walk_in;
      bin_ff    <= bin_in;
      lower_ff  <= lower_in;
      median_ff <= median_in;
      rsp_ff    <= rsp_in;
      if (accept) begin
         sample_ff <= sample_bin;
      end
      if (state_ff == S_SETTLE && walk_ff == '0) begin
         old_ff <= BinBits'(ring_q);
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

// ----- dv/testbench.sv -----
// Testbench for the sliding window median alert block: directed and random samples against a histogram predictor.
`timescale 1ns / 1ps
module testbench;
   localparam int Bins      = 256;
   localparam int WindowMax = 1024;
   localparam int CycleLimit = 10_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [swma_pkg::LengthWidth-1:0] csr_write_data = '0;

   swma_req_if req ();
   swma_rsp_if rsp ();

   sliding_window_median_alert dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // Clock: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: a private copy of the window.
   int unsigned hist_count [Bins];
   logic [7:0]  sample_ring [WindowMax];
   int unsigned ring_at;
   int unsigned fill_count;
   int unsigned alert_count;
   int unsigned length_reg;

   swma_pkg::rsp_type expected_beats [$];
   logic [7:0]  pending_samples [$];
   // Entries of -1 ask the driver to hold until every result has arrived.
   int          hold_marks [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   function automatic int unsigned active_length();
      if (length_reg < 1) return 1;
      if (length_reg > WindowMax) return WindowMax;
      return length_reg;
   endfunction

   function automatic void restart_window(int unsigned new_length);
      length_reg = new_length;
      foreach (hist_count[i]) hist_count[i] = 0;
      ring_at = 0;
      fill_count = 0;
   endfunction

   // Walk the histogram by prefix count; the two middle values summed for even lengths.
   function automatic int unsigned twice_median(int unsigned len);
      int unsigned middle;
      int unsigned running;
      middle = (len % 2 == 1) ? len / 2 : len / 2 - 1;
      running = 0;
      for (int i = 0; i < Bins; i++) begin
         running += hist_count[i];
         if (running > middle) begin
            if (len % 2 == 1 || running > middle + 1) return 2 * i;
            for (int j = i + 1; j < Bins; j++) begin
               if (hist_count[j] != 0) return i + j;
            end
            return 2 * i;
         end
      end
      return 0;
   endfunction

   // Advance the predictor by one accepted sample and queue the expected beat.
   function automatic void predict_sample(logic [7:0] value);
      int unsigned len;
      int unsigned pos;
      int unsigned med;
      swma_pkg::rsp_type beat;
      len = active_length();
      pos = ring_at % len;
      beat = '0;
      if (fill_count < len) begin
         hist_count[value]++;
         sample_ring[pos] = value;
         fill_count++;
      end else begin
         med = twice_median(len);
         beat.window_full = 1'b1;
         beat.doubled_median = med[swma_pkg::MedianWidth-1:0];
         if (value >= med) begin
            beat.alert = 1'b1;
            if (alert_count < 16'hFFFF) alert_count++;
         end
         if (hist_count[sample_ring[pos]] > 0) hist_count[sample_ring[pos]]--;
         hist_count[value]++;
         sample_ring[pos] = value;
      end
      ring_at = (pos + 1) % len;
      beat.alert_total = alert_count[swma_pkg::TotalWidth-1:0];
      expected_beats = {expected_beats, beat};
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // Driver: bursts of random length, random gaps between them.
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   bit          holding = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.sample_value <= '0;
      end else if (req.valid && !req.ready) begin
         // hold the beat until it is taken
      end else begin
         if (req.valid && req.ready) predict_sample(req.sample_value);
         if (holding && expected_beats.size() == 0 && !(req.valid && req.ready))
            holding = 1'b0;
         if (!holding && hold_marks.size() > 0 && hold_marks[0] == -1) begin
            void'(hold_marks.pop_front());
            holding = 1'b1;
         end
         if (holding || pending_samples.size() == 0) begin
            req.valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else begin
            req.valid <= 1'b1;
            req.sample_value <= pending_samples.pop_front();
            void'(hold_marks.pop_front());
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
            end
         end
      end
   end

   // Receiver: stall pattern drifts between modes.
   int unsigned stall_mode = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Monitor: compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      swma_pkg::rsp_type want;
      cycle_count++;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp.payload.window_full !== want.window_full)
               report_mismatch("window_full", rsp.payload.window_full, want.window_full);
            if (rsp.payload.doubled_median !== want.doubled_median)
               report_mismatch("doubled_median", rsp.payload.doubled_median,
                               want.doubled_median);
            if (rsp.payload.alert !== want.alert)
               report_mismatch("alert", rsp.payload.alert, want.alert);
            if (rsp.payload.alert_total !== want.alert_total)
               report_mismatch("alert_total", rsp.payload.alert_total, want.alert_total);
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("** sliding_window_median_alert: FAILED **");
         $finish;
      end
   end

   task automatic push_sample(logic [7:0] value);
      pending_samples = {pending_samples, value};
      hold_marks = {hold_marks, 0};
   endtask

   // Wait until everything queued was sent and answered, plus the block's drain time.
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req.valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (2 * Bins + 20) @(posedge clock);
   endtask

   task automatic write_length(int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value[swma_pkg::LengthWidth-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      restart_window(value);
   endtask

   // Draw a sample: half the time clustered near a level so medians settle, else random or an extreme.
   function automatic logic [7:0] draw_sample(int unsigned level);
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 255));
         1: return 8'hFF;
         2: return 8'h00;
         default: return 8'((level + $urandom_range(0, 15)) & 8'hFF);
      endcase
   endfunction

   initial begin
      int unsigned lengths [10];
      int unsigned len;
      int unsigned count;
      int unsigned level;
      lengths = '{1, 0, 2, 3, 4, 7, 16, 2047, 5, 1};
      restart_window(1);
      ring_at = 0;
      alert_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: length 1, extremes and doubled-median edge.
      push_sample(8'h00); push_sample(8'h00); push_sample(8'hFF); push_sample(8'h80);
      push_sample(8'h40); push_sample(8'h7F); push_sample(8'hFF); push_sample(8'h01);
      push_sample(8'h02); push_sample(8'h55); push_sample(8'hAA);
      wait_idle();
      // Even length: average of two middle values; also bit patterns.
      write_length(4);
      push_sample(8'h10); push_sample(8'h30); push_sample(8'h20); push_sample(8'h40);
      push_sample(8'h50); push_sample(8'h00); push_sample(8'hFF); push_sample(8'hF0);
      push_sample(8'h0F); push_sample(8'hA5); push_sample(8'h5A);
      wait_idle();

      // Random phases across lengths, including 0 and out-of-range values.
      for (int ph = 0; ph < 10; ph++) begin
         len = lengths[ph];
         write_length(len);
         count = 95;
         if (len > 100) count = active_length() + 60;
         level = $urandom_range(0, 240);
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 40) == 0) level = $urandom_range(0, 240);
            push_sample(draw_sample(level));
            if (k == count / 2) begin
               hold_marks = {hold_marks, -1};
            end
         end
         wait_idle();
      end
      if (error_count == 0) begin
         $display("** sliding_window_median_alert: PASSED **");
      end else begin
         $display("** sliding_window_median_alert: FAILED **");
      end
      $finish;
   end
endmodule

// ----- sliding_window_median_alert.f -----
design/swma_pkg.sv
design/swma_if.sv
design/swma_bin_cell.sv
design/sliding_window_median_alert.sv
dv/testbench.sv
